>>> hw/rtl/srt_pkg.sv
// Shared types and constants for the sorted record table.
// Used by the channel interfaces, the record memory and the top level.
package srt_pkg;

  localparam int DEPTH = 32;
  localparam int MAX_OUT = 32;

  localparam int KEY_W = 16;
  localparam int GROUP_W = 16;
  localparam int GRADE_W = 3;
  localparam int NUM_W = 6;

  localparam logic [GRADE_W-1:0] EXTRACT_GRADE_RST = 3'd2;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_FIND = 2'd2;
  localparam logic [1:0] ACT_EXTRACT = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [GROUP_W-1:0] group;
    logic [GRADE_W-1:0] grade;
  } rec_t;

endpackage

>>> hw/rtl/srt_req_if.sv
// Request channel of the sorted record table: valid/ready plus one command.
// Depends on srt_pkg for field widths.
interface srt_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [srt_pkg::KEY_W-1:0]    key;
  logic [srt_pkg::GROUP_W-1:0]  group;
  logic [srt_pkg::GRADE_W-1:0]  grade;

  modport source (output valid, action, key, group, grade, input ready);
  modport sink (input valid, action, key, group, grade, output ready);
endinterface

>>> hw/rtl/srt_rsp_if.sv
// Response channel of the sorted record table: valid/ready plus one result.
// Depends on srt_pkg for field widths.
interface srt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [srt_pkg::KEY_W-1:0]    out_key;
  logic [srt_pkg::GROUP_W-1:0]  out_group;
  logic [srt_pkg::GRADE_W-1:0]  out_grade;
  logic [srt_pkg::NUM_W-1:0]    removed;
  logic [srt_pkg::NUM_W-1:0]    count;
  logic                         last;

  modport source (output valid, status, out_key, out_group, out_grade, removed, count, last,
                  input ready);
  modport sink (input valid, status, out_key, out_group, out_grade, removed, count, last,
                output ready);
endinterface

>>> hw/rtl/srt_ram.sv
// Record memory: one write port and one read port with registered read data.
// Depends on srt_pkg for the record type.
module srt_ram #(
  parameter int DEPTH = srt_pkg::DEPTH
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  srt_pkg::rec_t                            wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output srt_pkg::rec_t                            rdata
);

  srt_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the read data until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/sorted_record_table.sv
// Sorted record table top level: sequencer, result register and config register.
// Depends on srt_pkg, srt_req_if, srt_rsp_if and srt_ram.
//
// Holds up to DEPTH records (key, group, grade) in ascending key order in one
// memory with a single read and a single write port; every entry visited passes
// through a read state and an execute state (address, then registered data), and
// the request side is not ready until the walk of an item is over. Insert walks
// down from the top, moving each record with a key at or above the new key up one
// place, then writes the new record; a full table gets a full status without a
// walk. Remove and find walk up from the bottom (find stops at the first hit); an
// empty table gets a miss without a walk. Extract makes two walks, one to count
// the matches and one to emit and compact; the second walk is left out when
// nothing matches. Each item gives one result beat, and extract one beat per
// record taken out; a stalled result beat holds the walk. The last beat of an
// item has last set.
module sorted_record_table #(
  parameter int DEPTH = srt_pkg::DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [srt_pkg::GRADE_W-1:0]   cfg_data,
  srt_req_if.sink                       req,
  srt_rsp_if.source                     rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int CAP = (DEPTH < srt_pkg::MAX_OUT) ? DEPTH : srt_pkg::MAX_OUT;
  localparam int NW = srt_pkg::NUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]                  state, state_next;
  logic [CW-1:0]               idx, idx_next;
  logic [CW-1:0]               wr, wr_next;
  logic [CW-1:0]               cnt, cnt_next;
  logic [CW-1:0]               nmatch, nmatch_next;
  logic [CW-1:0]               nemit, nemit_next;
  logic                        pass, pass_next;
  logic [1:0]                  fin_status, fin_status_next;
  srt_pkg::rec_t               fin_rec, fin_rec_next;
  logic [NW-1:0]               fin_removed, fin_removed_next;
  logic [srt_pkg::GRADE_W-1:0] extract_grade;

  logic [1:0]                  act;
  srt_pkg::rec_t               req_rec;

  logic                        out_valid;
  logic [1:0]                  o_status;
  srt_pkg::rec_t               o_rec;
  logic [NW-1:0]               o_removed;
  logic [NW-1:0]               o_count;
  logic                        o_last;

  logic                        load;
  logic [1:0]                  ld_status;
  srt_pkg::rec_t               ld_rec;
  logic [NW-1:0]               ld_removed;
  logic [NW-1:0]               ld_count;
  logic                        ld_last;

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  srt_pkg::rec_t               mem_wdata;
  logic                        mem_re;
  srt_pkg::rec_t               rd_data;

  logic                        accept;
  logic                        slot_free;
  logic                        at_end;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_free = !out_valid || rsp.ready;
  assign at_end    = ((idx + CW'(1)) == cnt);
  assign mem_re    = (state == S_READ);

  srt_ram #(.DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    logic [CW-1:0] nm_new;
    logic          take;

    nm_new           = nmatch;
    take             = 1'b0;
    state_next       = state;
    idx_next         = idx;
    wr_next          = wr;
    cnt_next         = cnt;
    nmatch_next      = nmatch;
    nemit_next       = nemit;
    pass_next        = pass;
    fin_status_next  = fin_status;
    fin_rec_next     = fin_rec;
    fin_removed_next = fin_removed;
    mem_we           = 1'b0;
    mem_waddr        = wr[AW-1:0];
    mem_wdata        = rd_data;
    load             = 1'b0;
    ld_status        = srt_pkg::ST_DONE;
    ld_rec           = '0;
    ld_removed       = '0;
    ld_count         = NW'(cnt);
    ld_last          = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next         = '0;
          wr_next          = '0;
          nmatch_next      = '0;
          nemit_next       = '0;
          pass_next        = 1'b0;
          fin_rec_next     = '0;
          fin_removed_next = '0;
          fin_status_next  = srt_pkg::ST_DONE;
          if (req.action == srt_pkg::ACT_INSERT) begin
            if (cnt == CW'(DEPTH)) begin
              fin_status_next = srt_pkg::ST_FULL;
              state_next      = S_FIN;
            end else if (cnt == '0) begin
              state_next = S_PUT;
            end else begin
              idx_next   = cnt - CW'(1);
              state_next = S_READ;
            end
          end else if (cnt == '0) begin
            fin_status_next = srt_pkg::ST_MISS;
            state_next      = S_FIN;
          end else begin
            state_next = S_READ;
          end
        end
      end

      S_READ: begin
        state_next = S_EXEC;
      end

      S_EXEC: begin
        case (act)
          srt_pkg::ACT_INSERT: begin
            if (rd_data.key >= req_rec.key) begin
              // move this record up one place and carry on downwards
              mem_we    = 1'b1;
              mem_waddr = AW'(idx + CW'(1));
              if (idx == '0) begin
                wr_next    = '0;
                state_next = S_PUT;
              end else begin
                idx_next   = idx - CW'(1);
                state_next = S_READ;
              end
            end else begin
              wr_next    = idx + CW'(1);
              state_next = S_PUT;
            end
          end

          srt_pkg::ACT_REMOVE: begin
            if (rd_data.group != req_rec.group) begin
              mem_we  = 1'b1;
              wr_next = wr + CW'(1);
            end
            if (at_end) begin
              cnt_next         = wr_next;
              fin_removed_next = NW'(cnt - wr_next);
              fin_status_next  = (cnt == wr_next) ? srt_pkg::ST_MISS : srt_pkg::ST_DONE;
              state_next       = S_FIN;
            end else begin
              idx_next   = idx + CW'(1);
              state_next = S_READ;
            end
          end

          srt_pkg::ACT_FIND: begin
            if (rd_data.key == req_rec.key) begin
              fin_rec_next    = rd_data;
              fin_status_next = srt_pkg::ST_DONE;
              state_next      = S_FIN;
            end else if (at_end) begin
              fin_status_next = srt_pkg::ST_MISS;
              state_next      = S_FIN;
            end else begin
              idx_next   = idx + CW'(1);
              state_next = S_READ;
            end
          end

          default: begin
            if (!pass) begin
              // first walk: count the records to take out
              if (rd_data.grade == extract_grade && nmatch < CW'(CAP)) begin
                nm_new = nmatch + CW'(1);
              end
              nmatch_next = nm_new;
              if (at_end) begin
                idx_next = '0;
                if (nm_new == '0) begin
                  fin_status_next = srt_pkg::ST_MISS;
                  state_next      = S_FIN;
                end else begin
                  pass_next  = 1'b1;
                  state_next = S_READ;
                end
              end else begin
                idx_next   = idx + CW'(1);
                state_next = S_READ;
              end
            end else begin
              take = (rd_data.grade == extract_grade) && (nemit < nmatch);
              // hold while the result register is still occupied
              if (!take || slot_free) begin
                if (take) begin
                  load       = 1'b1;
                  ld_status  = srt_pkg::ST_EMIT;
                  ld_rec     = rd_data;
                  ld_count   = NW'(cnt - nmatch);
                  ld_last    = ((nemit + CW'(1)) == nmatch);
                  nemit_next = nemit + CW'(1);
                end else begin
                  mem_we  = 1'b1;
                  wr_next = wr + CW'(1);
                end
                if (at_end) begin
                  cnt_next   = cnt - nmatch;
                  state_next = S_IDLE;
                end else begin
                  idx_next   = idx + CW'(1);
                  state_next = S_READ;
                end
              end
            end
          end
        endcase
      end

      S_PUT: begin
        mem_we          = 1'b1;
        mem_waddr       = wr[AW-1:0];
        mem_wdata       = req_rec;
        cnt_next        = cnt + CW'(1);
        fin_status_next = srt_pkg::ST_DONE;
        state_next      = S_FIN;
      end

      S_FIN: begin
        if (slot_free) begin
          load       = 1'b1;
          ld_status  = fin_status;
          ld_rec     = fin_rec;
          ld_removed = fin_removed;
          ld_count   = NW'(cnt);
          ld_last    = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      out_valid     <= 1'b0;
      extract_grade <= srt_pkg::EXTRACT_GRADE_RST;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        extract_grade <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx         <= idx_next;
    wr          <= wr_next;
    nmatch      <= nmatch_next;
    nemit       <= nemit_next;
    pass        <= pass_next;
    fin_status  <= fin_status_next;
    fin_rec     <= fin_rec_next;
    fin_removed <= fin_removed_next;
    if (accept) begin
      act           <= req.action;
      req_rec.key   <= req.key;
      req_rec.group <= req.group;
      req_rec.grade <= req.grade;
    end
    if (load) begin
      o_status  <= ld_status;
      o_rec     <= ld_rec;
      o_removed <= ld_removed;
      o_count   <= ld_count;
      o_last    <= ld_last;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = o_status;
  assign rsp.out_key   = o_rec.key;
  assign rsp.out_group = o_rec.group;
  assign rsp.out_grade = o_rec.grade;
  assign rsp.removed   = o_removed;
  assign rsp.count     = o_count;
  assign rsp.last      = o_last;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_full_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == srt_pkg::ACT_INSERT && cnt == CW'(DEPTH)) |=> cnt == $past(cnt))
    else $error("insert into a full table changed the count");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && act != srt_pkg::ACT_INSERT) |-> wr <= idx)
    else $error("compaction write pointer ahead of read pointer");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && o_status == srt_pkg::ST_FULL) |-> o_count == NW'(DEPTH))
    else $error("table full reported with a count below depth");
`endif

endmodule
